// ----- hdl/mlr_pkg.sv -----
`default_nettype none
package mlr_pkg;

	// Octant case of the walk, fixed once per line.
	typedef enum logic [1:0] {
		OCT_RISE_SHALLOW = 2'd0,
		OCT_RISE_STEEP   = 2'd1,
		OCT_FALL_SHALLOW = 2'd2,
		OCT_FALL_STEEP   = 2'd3
	} octant_t;

	// Sequencer commands to the walker.
	typedef struct packed {
		logic load;
		logic advance;
	} walk_ctrl_t;

	localparam int unsigned COLOR_BITS = 24;

endpackage
`default_nettype wire

// ----- hdl/mlr_setup.sv -----
`default_nettype none
module mlr_setup import mlr_pkg::*; #(
	parameter int unsigned COORD_BITS = 6,
	parameter int unsigned DEC_BITS   = COORD_BITS + 4
) (
	input  wire logic [COORD_BITS-1:0]      x0,
	input  wire logic [COORD_BITS-1:0]      y0,
	input  wire logic [COORD_BITS-1:0]      x1,
	input  wire logic [COORD_BITS-1:0]      y1,
	output logic [COORD_BITS-1:0]           init_x,
	output logic [COORD_BITS-1:0]           init_y,
	output logic signed [DEC_BITS-1:0]      init_dec,
	output logic signed [DEC_BITS-1:0]      init_straight,
	output logic signed [DEC_BITS-1:0]      init_diagonal,
	output logic [COORD_BITS-1:0]           init_stop,
	output octant_t                         init_oct
);

	localparam int unsigned PAD = DEC_BITS - COORD_BITS;

	logic                       swap;
	logic [COORD_BITS-1:0]      ax, ay, bx, by;
	logic signed [DEC_BITS-1:0] dx, dy, ady, dd, base, addend;
	logic                       steep, falling;

	always_comb begin
		// order endpoints so x does not fall; equal x keeps given order
		swap = x0 > x1;
		ax   = swap ? x1 : x0;
		ay   = swap ? y1 : y0;
		bx   = swap ? x0 : x1;
		by   = swap ? y0 : y1;

		dx      = signed'({{PAD{1'b0}}, bx}) - signed'({{PAD{1'b0}}, ax});
		dy      = signed'({{PAD{1'b0}}, by}) - signed'({{PAD{1'b0}}, ay});
		falling = dy[DEC_BITS-1];
		ady     = falling ? -dy : dy;
		steep   = ady >= dx;

		dd            = falling ? (dy + dx) : (dy - dx);
		init_diagonal = dd <<< 1;

		if (!steep) begin
			init_straight = dy <<< 1;
		end else if (falling) begin
			init_straight = dx <<< 1;
		end else begin
			init_straight = -(dx <<< 1);
		end

		base     = steep ? dy : init_straight;
		addend   = steep ? init_straight : (falling ? dx : -dx);
		init_dec = base + addend;

		init_x    = ax;
		init_y    = ay;
		init_stop = steep ? by : bx;

		if (falling) begin
			init_oct = steep ? OCT_FALL_STEEP : OCT_FALL_SHALLOW;
		end else begin
			init_oct = steep ? OCT_RISE_STEEP : OCT_RISE_SHALLOW;
		end
	end

endmodule
`default_nettype wire

// ----- hdl/mlr_walk.sv -----
`default_nettype none
module mlr_walk import mlr_pkg::*; #(
	parameter int unsigned COORD_BITS = 6,
	parameter int unsigned DEC_BITS   = COORD_BITS + 4
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire walk_ctrl_t                 ctrl,
	input  wire logic [COORD_BITS-1:0]      init_x,
	input  wire logic [COORD_BITS-1:0]      init_y,
	input  wire logic signed [DEC_BITS-1:0] init_dec,
	input  wire logic signed [DEC_BITS-1:0] init_straight,
	input  wire logic signed [DEC_BITS-1:0] init_diagonal,
	input  wire logic [COORD_BITS-1:0]      init_stop,
	input  wire octant_t                    init_oct,
	output logic [COORD_BITS-1:0]           cur_x,
	output logic [COORD_BITS-1:0]           cur_y,
	output logic                            is_last
);

	localparam logic [COORD_BITS-1:0] ONE = COORD_BITS'(1);

	logic [COORD_BITS-1:0]      cur_x_q, cur_y_q, stop_q;
	logic signed [DEC_BITS-1:0] dec_q, straight_q, diagonal_q;
	octant_t                    oct_q;

	logic                       pos, take_diag;
	logic signed [DEC_BITS-1:0] dec_next;
	logic [COORD_BITS-1:0]      x_next, y_next;

	always_comb begin
		pos = !dec_q[DEC_BITS-1] && (dec_q != '0);
		take_diag = (oct_q == OCT_RISE_SHALLOW || oct_q == OCT_FALL_STEEP) ? pos : !pos;
		// the one shared adder
		dec_next = dec_q + (take_diag ? diagonal_q : straight_q);
		x_next = cur_x_q;
		y_next = cur_y_q;
		unique case (oct_q)
			OCT_RISE_SHALLOW: begin
				x_next = cur_x_q + ONE;
				if (take_diag) y_next = cur_y_q + ONE;
			end
			OCT_RISE_STEEP: begin
				y_next = cur_y_q + ONE;
				if (take_diag) x_next = cur_x_q + ONE;
			end
			OCT_FALL_SHALLOW: begin
				x_next = cur_x_q + ONE;
				if (take_diag) y_next = cur_y_q - ONE;
			end
			OCT_FALL_STEEP: begin
				y_next = cur_y_q - ONE;
				if (take_diag) x_next = cur_x_q + ONE;
			end
			default: begin
				x_next = cur_x_q;
				y_next = cur_y_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q    <= '0;
			cur_y_q    <= '0;
			stop_q     <= '0;
			dec_q      <= '0;
			straight_q <= '0;
			diagonal_q <= '0;
			oct_q      <= OCT_RISE_SHALLOW;
		end else if (ctrl.load) begin
			cur_x_q    <= init_x;
			cur_y_q    <= init_y;
			stop_q     <= init_stop;
			dec_q      <= init_dec;
			straight_q <= init_straight;
			diagonal_q <= init_diagonal;
			oct_q      <= init_oct;
		end else if (ctrl.advance) begin
			cur_x_q <= x_next;
			cur_y_q <= y_next;
			dec_q   <= dec_next;
		end
	end

	assign cur_x   = cur_x_q;
	assign cur_y   = cur_y_q;
	// major axis reaching the far endpoint marks the last pixel
	assign is_last = (oct_q == OCT_RISE_STEEP || oct_q == OCT_FALL_STEEP) ?
		(cur_y_q == stop_q) : (cur_x_q == stop_q);

	a_no_step_past_end: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.advance |-> !is_last) else $error("walker stepped past the end point");

	a_load_excl: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.load |-> !ctrl.advance) else $error("load and advance together");

	a_steps_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!ctrl.load |=> $stable(straight_q) && $stable(diagonal_q) && $stable(oct_q))
		else $error("increments changed mid-line");

endmodule
`default_nettype wire

// ----- hdl/midpoint_line_rasterizer_core.sv -----
`default_nettype none
// Midpoint line rasterizer core.
// s_axis: one item per line command, two endpoints in a tile grid.
//   Accepted when s_axis_tvalid and s_axis_tready are high at a clock edge.
//   s_axis_tready is high only while no line is in progress.
// m_axis: one item per pixel, in walk order from the lower-x endpoint;
//   m_axis_tlast marks the final pixel of the line.
// cfg: write channel for the pixel color, always ready; write it only
//   while the core is idle. The value is attached to every pixel.
// Sequence: accept in idle, a setup state that loads the walker, then one
//   pixel per cycle on the walk while the receiver does not stall. A line of
//   N = max(|dx|,|dy|) steps gives N+1 pixels, and the next command can be
//   taken once the last pixel is registered. The walk rate is set by the
//   single decision adder, which does one midpoint step per cycle unless stalled.
// First pixel: setup loads the walker, then walk fills the output register.
// Receiver stall: the output register holds its pixel and the walk waits;
//   nothing is lost. After the last pixel is registered a new command is
//   accepted even if that pixel is still waiting.
// Reset (arst_n low, asynchronous): idle, output empty, color zero.
module midpoint_line_rasterizer_core import mlr_pkg::*; #(
	parameter int unsigned COORD_BITS = 6
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// s_axis_tdata: start_x, start_y, end_x, end_y (lowest bits first)
	input  wire logic [((4*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	// m_axis_tdata: pixel_x, pixel_y, color (lowest bits first)
	output logic [((2*COORD_BITS+COLOR_BITS+7)/8)*8-1:0] m_axis_tdata,
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	output logic                       m_axis_tlast,
	// configuration: pixel_color
	input  wire logic [COLOR_BITS-1:0] cfg_data,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready
);

	localparam int unsigned DEC_BITS = COORD_BITS + 4;
	localparam int unsigned OUT_TW   = ((2*COORD_BITS+COLOR_BITS+7)/8)*8;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SETUP = 3'b010,
		ST_WALK  = 3'b100
	} state_t;

	state_t state_q, state_d;

	// latched command
	logic [COORD_BITS-1:0] x0_q, y0_q, x1_q, y1_q;
	// configured color
	logic [COLOR_BITS-1:0] pixel_color_q;
	// output register
	logic                  out_valid_q, out_last_q;
	logic [COORD_BITS-1:0] out_x_q, out_y_q;
	logic [COLOR_BITS-1:0] out_color_q;

	logic                       in_fire, out_free, out_load;
	walk_ctrl_t                 wctrl;
	logic [COORD_BITS-1:0]      init_x, init_y, init_stop, cur_x, cur_y;
	logic signed [DEC_BITS-1:0] init_dec, init_straight, init_diagonal;
	octant_t                    init_oct;
	logic                       walk_last;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign out_load      = (state_q == ST_WALK) && out_free;

	// sequencer
	always_comb begin
		state_d       = state_q;
		wctrl.load    = 1'b0;
		wctrl.advance = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) state_d = ST_SETUP;
			end
			ST_SETUP: begin
				wctrl.load = 1'b1;
				state_d    = ST_WALK;
			end
			ST_WALK: begin
				if (out_free) begin
					if (walk_last) state_d = ST_IDLE;
					else wctrl.advance = 1'b1;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			pixel_color_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) pixel_color_q <= cfg_data;
			if (out_load) out_valid_q <= 1'b1;
			else if (m_axis_tready) out_valid_q <= 1'b0;
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (in_fire) begin
			x0_q <= s_axis_tdata[COORD_BITS-1:0];
			y0_q <= s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
			x1_q <= s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS];
			y1_q <= s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS];
		end
		if (out_load) begin
			out_x_q     <= cur_x;
			out_y_q     <= cur_y;
			out_color_q <= pixel_color_q;
			out_last_q  <= walk_last;
		end
	end

	mlr_setup #(
		.COORD_BITS (COORD_BITS),
		.DEC_BITS   (DEC_BITS)
	) u_setup (
		.x0            (x0_q),
		.y0            (y0_q),
		.x1            (x1_q),
		.y1            (y1_q),
		.init_x        (init_x),
		.init_y        (init_y),
		.init_dec      (init_dec),
		.init_straight (init_straight),
		.init_diagonal (init_diagonal),
		.init_stop     (init_stop),
		.init_oct      (init_oct)
	);

	mlr_walk #(
		.COORD_BITS (COORD_BITS),
		.DEC_BITS   (DEC_BITS)
	) u_walk (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (wctrl),
		.init_x        (init_x),
		.init_y        (init_y),
		.init_dec      (init_dec),
		.init_straight (init_straight),
		.init_diagonal (init_diagonal),
		.init_stop     (init_stop),
		.init_oct      (init_oct),
		.cur_x         (cur_x),
		.cur_y         (cur_y),
		.is_last       (walk_last)
	);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = OUT_TW'({out_color_q, out_y_q, out_x_q});

	a_accept_to_setup: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> state_q == ST_SETUP) else $error("command not followed by setup");

	a_last_ends_line: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && walk_last |=> state_q == ST_IDLE && m_axis_tvalid && m_axis_tlast)
		else $error("last pixel did not end the line");

	a_pixel_only_walking: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> !s_axis_tready) else $error("pixel emitted while idle");

endmodule
`default_nettype wire

// ----- test/tb_midpoint_line_rasterizer_core.sv -----
`default_nettype none
module tb_midpoint_line_rasterizer_core import mlr_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned COORD_BITS = 6;
	localparam int unsigned IN_W  = ((4*COORD_BITS+7)/8)*8;
	localparam int unsigned OUT_W = ((2*COORD_BITS+COLOR_BITS+7)/8)*8;
	// hard stop for a run that hangs, checked by the watchdog
	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int unsigned ITEMS_PER_PHASE = 75;

	// one plotted pixel, as it shows up on m_axis
	typedef struct packed {
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic [COLOR_BITS-1:0] color;
		logic                  last;
	} pixel_t;

	// directed line command; pinned rows carry their one pixel typed in
	typedef struct packed {
		logic [COORD_BITS-1:0] sx;
		logic [COORD_BITS-1:0] sy;
		logic [COORD_BITS-1:0] ex;
		logic [COORD_BITS-1:0] ey;
		logic                  pinned;
		logic [COORD_BITS-1:0] px;
		logic [COORD_BITS-1:0] py;
	} line_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic [IN_W-1:0]       s_axis_tdata;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [OUT_W-1:0]      m_axis_tdata;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic                  m_axis_tlast;
	logic [COLOR_BITS-1:0] cfg_data;
	logic                  cfg_valid;
	logic                  cfg_ready;

	// sideband that travels with the command being offered
	logic                  row_pinned;
	logic [COORD_BITS-1:0] row_px;
	logic [COORD_BITS-1:0] row_py;

	// model state: the color register and the pixels still owed
	logic [COLOR_BITS-1:0] line_color;
	pixel_t                pixels_due[$];
	int                    mismatches;
	int                    cycle_count;
	int                    send_idle_pct;
	int                    recv_idle_pct;

	// Walk order: bottom-up endpoint pins, straight/diagonal extremes,
	// all four octants, the d == 0 tie in each octant, a swapped pair,
	// and a vertical line whose given order has to be kept.
	line_row_t directed_lines [21] = '{
		'{0,  0,  0,  0,  1, 0,  0},	// single point, origin
		'{63, 63, 63, 63, 1, 63, 63},	// single point, far corner
		'{63, 0,  63, 0,  1, 63, 0},
		'{0,  63, 0,  63, 1, 0,  63},
		'{0,  0,  63, 0,  0, 0,  0},	// full-width horizontal
		'{63, 63, 0,  63, 0, 0,  0},	// horizontal, endpoints swapped
		'{0,  0,  0,  63, 0, 0,  0},	// vertical up
		'{63, 63, 63, 0,  0, 0,  0},	// vertical down -> falling steep
		'{0,  0,  63, 63, 0, 0,  0},	// main diagonal
		'{0,  63, 63, 0,  0, 0,  0},	// anti-diagonal
		'{63, 63, 0,  0,  0, 0,  0},
		'{0,  0,  63, 21, 0, 0,  0},	// rising shallow
		'{4,  1,  11, 62, 0, 0,  0},	// rising steep
		'{2,  40, 61, 29, 0, 0,  0},	// falling shallow
		'{10, 60, 21, 3,  0, 0,  0},	// falling steep
		'{0,  0,  2,  1,  0, 0,  0},	// ties: decision starts at zero
		'{0,  0,  1,  2,  0, 0,  0},
		'{0,  1,  2,  0,  0, 0,  0},
		'{0,  2,  1,  0,  0, 0,  0},
		'{50, 10, 5,  30, 0, 0,  0},	// swapped shallow
		'{7,  9,  7,  3,  0, 0,  0}	// equal x, drawn downward as given
	};

	midpoint_line_rasterizer_core #(
		.COORD_BITS(COORD_BITS)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tlast (m_axis_tlast),
		.cfg_data     (cfg_data),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready)
	);

	// 12 ns period, low half first
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Midpoint walk for one command: order by x, pick the octant, then step
	// the decision term once per pixel. Pushes every pixel it plots.
	task automatic plot_line(input logic [IN_W-1:0] word);
		int                    x0, y0, x1, y1, tmp, dx, dy, ady, steps;
		logic signed [9:0]     d, inc_str, inc_diag;
		logic                  steep, falling;
		octant_t               oct;
		logic [COORD_BITS-1:0] px, py;
		x0 = int'(word[5:0]);
		y0 = int'(word[11:6]);
		x1 = int'(word[17:12]);
		y1 = int'(word[23:18]);
		if (x0 > x1) begin
			tmp = x0; x0 = x1; x1 = tmp;
			tmp = y0; y0 = y1; y1 = tmp;
		end
		dx = x1 - x0;
		dy = y1 - y0;
		ady = (dy < 0) ? -dy : dy;
		steep = (ady >= dx);
		falling = (dy < 0);
		if (!falling) begin
			inc_diag = 10'(2 * (dy - dx));
			if (steep) begin
				inc_str = 10'(-2 * dx);
				d = 10'(dy - 2 * dx);
				oct = OCT_RISE_STEEP;
			end else begin
				inc_str = 10'(2 * dy);
				d = 10'(2 * dy - dx);
				oct = OCT_RISE_SHALLOW;
			end
		end else begin
			inc_diag = 10'(2 * (dy + dx));
			if (steep) begin
				inc_str = 10'(2 * dx);
				d = 10'(dy + 2 * dx);
				oct = OCT_FALL_STEEP;
			end else begin
				inc_str = 10'(2 * dy);
				d = 10'(2 * dy + dx);
				oct = OCT_FALL_SHALLOW;
			end
		end
		steps = steep ? ady : dx;
		px = COORD_BITS'(x0);
		py = COORD_BITS'(y0);
		pixels_due.push_back('{x: px, y: py, color: line_color, last: (steps == 0)});
		for (int i = 1; i <= steps; i++) begin
			// tie rule: d == 0 falls to the "not positive" branch everywhere
			case (oct)
				OCT_RISE_SHALLOW: begin
					if (d > 0) begin
						d += inc_diag;
						py++;
					end else
						d += inc_str;
					px++;
				end
				OCT_RISE_STEEP: begin
					if (d > 0)
						d += inc_str;
					else begin
						d += inc_diag;
						px++;
					end
					py++;
				end
				OCT_FALL_SHALLOW: begin
					if (d > 0)
						d += inc_str;
					else begin
						d += inc_diag;
						py--;
					end
					px++;
				end
				default: begin
					if (d > 0) begin
						d += inc_diag;
						px++;
					end else
						d += inc_str;
					py--;
				end
			endcase
			pixels_due.push_back('{x: px, y: py, color: line_color, last: (i == steps)});
		end
	endtask

	// Random command: mostly short lines and the special shapes, the rest
	// fully random endpoints so every coordinate bit toggles.
	function automatic logic [IN_W-1:0] random_line();
		logic [COORD_BITS-1:0] x0, y0, x1, y1, t;
		int                    pick, len;
		x0 = COORD_BITS'($urandom);
		y0 = COORD_BITS'($urandom);
		x1 = COORD_BITS'($urandom);
		y1 = COORD_BITS'($urandom);
		pick = $urandom_range(99);
		if (pick < 30) begin
			// short line, stays inside the tile
			x1 = x0 ^ 6'($urandom_range(7));
			y1 = y0 ^ 6'($urandom_range(7));
		end else if (pick < 40)
			y1 = y0;
		else if (pick < 50)
			x1 = x0;
		else if (pick < 58) begin
			// 45-degree line, either slope, either order
			len = $urandom_range(63);
			x0 = COORD_BITS'($urandom_range(63 - len));
			y0 = COORD_BITS'($urandom_range(63 - len));
			x1 = COORD_BITS'(int'(x0) + len);
			y1 = COORD_BITS'(int'(y0) + len);
			if ($urandom_range(1)) begin
				t = y0; y0 = y1; y1 = t;
			end
			if ($urandom_range(1)) begin
				t = x0; x0 = x1; x1 = t;
				t = y0; y0 = y1; y1 = t;
			end
		end else if (pick < 63) begin
			x1 = x0;
			y1 = y0;
		end
		return {y1, x1, y0, x0};
	endfunction

	// Offer one command: random gap first, then hold it until taken.
	// Entered and left on a falling edge.
	task automatic send_line(input logic [IN_W-1:0] word, input logic pinned,
			input logic [COORD_BITS-1:0] px, input logic [COORD_BITS-1:0] py);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= word;
		row_pinned <= pinned;
		row_px <= px;
		row_py <= py;
		do
			@(posedge clk);
		while (!s_axis_tready);
		@(negedge clk);
	endtask

	// Drop valid and let every owed pixel drain, then wait out a margin.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pixels_due.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// Color write, only issued while the core is idle.
	task automatic write_color(input logic [COLOR_BITS-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Receiver back-pressure, redrawn every cycle.
	always @(negedge clk)
		m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

	// Everything sampled on the rising edge: color writes, accepted
	// commands (which fill the expected pixels), and pixels to check.
	always @(posedge clk) begin : scoreboard
		pixel_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				line_color = cfg_data;
			if (s_axis_tvalid && s_axis_tready) begin
				if (row_pinned)
					pixels_due.push_back('{x: row_px, y: row_py, color: line_color,
						last: 1'b1});
				else
					plot_line(s_axis_tdata);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (pixels_due.size() == 0) begin
					$error("pixel with nothing owed: x %0d y %0d", m_axis_tdata[5:0],
						m_axis_tdata[11:6]);
					mismatches++;
				end else begin
					want = pixels_due.pop_front();
					if (m_axis_tdata[5:0] !== want.x) begin
						$error("pixel_x: expected %0d, got %0d", want.x, m_axis_tdata[5:0]);
						mismatches++;
					end
					if (m_axis_tdata[11:6] !== want.y) begin
						$error("pixel_y: expected %0d, got %0d", want.y, m_axis_tdata[11:6]);
						mismatches++;
					end
					if (m_axis_tdata[35:12] !== want.color) begin
						$error("color: expected %06h, got %06h", want.color,
							m_axis_tdata[35:12]);
						mismatches++;
					end
					if (m_axis_tlast !== want.last) begin
						$error("last: expected %0d, got %0d", want.last, m_axis_tlast);
						mismatches++;
					end
				end
			end
		end else
			line_color = '0;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_axis_tdata = '0;
		s_axis_tvalid = 1'b0;
		cfg_data = '0;
		cfg_valid = 1'b0;
		row_pinned = 1'b0;
		row_px = '0;
		row_py = '0;
		send_idle_pct = 24;
		recv_idle_pct = 58;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed lines run with the color still at its reset value
		foreach (directed_lines[i])
			send_line({directed_lines[i].ey, directed_lines[i].ex,
				directed_lines[i].sy, directed_lines[i].sx},
				directed_lines[i].pinned, directed_lines[i].px, directed_lines[i].py);
		drain();

		// two color settings per idle mode; all-ones and zero come first
		for (int phase = 0; phase < 6; phase++) begin
			case (phase / 2)
				0: begin
					send_idle_pct = 24;
					recv_idle_pct = 58;
				end
				1: begin
					send_idle_pct = 58;
					recv_idle_pct = 24;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			if (phase == 0)
				write_color({COLOR_BITS{1'b1}});
			else if (phase == 1)
				write_color('0);
			else
				write_color(COLOR_BITS'($urandom));
			repeat (ITEMS_PER_PHASE)
				send_line(random_line(), 1'b0, '0, '0);
			drain();
		end

		if (pixels_due.size() != 0)
			$error("%0d pixels never arrived", pixels_due.size());
		if (mismatches == 0 && pixels_due.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
`default_nettype wire
